// File: sv/chsh_correlation_witness_assert.svh
// Assertion macros used by the checker file of the correlation witness.
`ifndef CHSH_CORRELATION_WITNESS_ASSERT_SVH
`define CHSH_CORRELATION_WITNESS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define CHSHCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("chshcw assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define CHSHCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("chshcw assertion failed");

`endif

// File: sv/chshcw_pkg.sv
// Shared types and constants of the CHSH correlation witness.
package chshcw_pkg;

  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 88;

  // Bit positions of the result beat as the core packs it, used by the checker.
  localparam int unsigned OUT_REARM_BIT = 0;
  localparam int unsigned OUT_SHOT_BIT  = 1;
  localparam int unsigned OUT_S_LSB     = 2;
  localparam int unsigned OUT_S_MSB     = 17;
  localparam int unsigned OUT_VIOL_BIT  = 18;

  // Register indexes (paddr[4:2]).
  localparam logic [2:0] REG_SHOTS_PER_PAIR = 3'd0;
  localparam logic [2:0] REG_SETTLE_US      = 3'd1;
  localparam logic [2:0] REG_ANGLE_A        = 3'd2;
  localparam logic [2:0] REG_ANGLE_A_PRIME  = 3'd3;
  localparam logic [2:0] REG_ANGLE_B        = 3'd4;
  localparam logic [2:0] REG_ANGLE_B_PRIME  = 3'd5;

  localparam logic [15:0] RST_SHOTS_PER_PAIR = 16'd64;
  localparam logic [31:0] RST_SETTLE_US      = 32'd1000000;
  localparam logic [15:0] RST_ANGLE_A        = 16'd0;
  localparam logic [15:0] RST_ANGLE_A_PRIME  = 16'd12868;
  localparam logic [15:0] RST_ANGLE_B        = 16'd6434;
  localparam logic [15:0] RST_ANGLE_B_PRIME  = 16'd19302;

  // Setting pairs: the (a, b') pair enters S with a minus sign.
  localparam logic [1:0] PAIR_AB_PRIME = 2'd1;
  localparam logic [1:0] PAIR_LAST     = 2'd3;

  typedef struct packed {
    logic [15:0] shots_per_pair;
    logic [31:0] settle_us;
    logic [15:0] angle_a;
    logic [15:0] angle_a_prime;
    logic [15:0] angle_b;
    logic [15:0] angle_b_prime;
  } cfg_t;

  typedef struct packed {
    logic        second_bit;
    logic        second_ok;
    logic        first_bit;
    logic        first_ok;
    logic [19:0] delta_us;
  } frame_t;

  typedef struct packed {
    logic        rearm;
    logic        shot_taken;
    logic        report_valid;
    logic        violation;
    logic [15:0] s_estimate;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TIMER,
    ST_CHECK,
    ST_RCHK,
    ST_LOAD,
    ST_CLAMP,
    ST_DSTART,
    ST_DWAIT,
    ST_ACC,
    ST_SAT,
    ST_DONE
  } state_e;

endpackage

// File: sv/chshcw_regs.sv
// Configuration register file of the correlation witness behind an APB-style port.
module chshcw_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [chshcw_pkg::PADDR_W-1:0] paddr,
  input  logic [chshcw_pkg::PDATA_W-1:0] pwdata,
  output logic [chshcw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output chshcw_pkg::cfg_t             cfg_o
);
  import chshcw_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SHOTS_PER_PAIR: cfg_d.shots_per_pair = pwdata[15:0];
        REG_SETTLE_US:      cfg_d.settle_us      = pwdata;
        REG_ANGLE_A:        cfg_d.angle_a        = pwdata[15:0];
        REG_ANGLE_A_PRIME:  cfg_d.angle_a_prime  = pwdata[15:0];
        REG_ANGLE_B:        cfg_d.angle_b        = pwdata[15:0];
        REG_ANGLE_B_PRIME:  cfg_d.angle_b_prime  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHOTS_PER_PAIR: prdata = {16'd0, cfg_q.shots_per_pair};
      REG_SETTLE_US:      prdata = cfg_q.settle_us;
      REG_ANGLE_A:        prdata = {16'd0, cfg_q.angle_a};
      REG_ANGLE_A_PRIME:  prdata = {16'd0, cfg_q.angle_a_prime};
      REG_ANGLE_B:        prdata = {16'd0, cfg_q.angle_b};
      REG_ANGLE_B_PRIME:  prdata = {16'd0, cfg_q.angle_b_prime};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shots_per_pair <= RST_SHOTS_PER_PAIR;
      cfg_q.settle_us      <= RST_SETTLE_US;
      cfg_q.angle_a        <= RST_ANGLE_A;
      cfg_q.angle_a_prime  <= RST_ANGLE_A_PRIME;
      cfg_q.angle_b        <= RST_ANGLE_B;
      cfg_q.angle_b_prime  <= RST_ANGLE_B_PRIME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/chshcw_serdiv.sv
// Radix-2 serial divider giving round(dividend * 2^FRAC_BITS / divisor), one bit a cycle.
module chshcw_serdiv #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COUNT_WIDTH-1:0] dividend_i,
  input  logic [COUNT_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [FRAC_BITS:0]     quot_o
);
  // The dividend never exceeds the divisor, so the integer part is one bit and
  // FRAC_BITS+1 fraction bits follow; the last one decides the rounding.
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned StepW = $clog2(FRAC_BITS + 2);

  logic [COUNT_WIDTH-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [QW:0]            qs_q, qs_d;
  logic [StepW-1:0]       step_q, step_d;
  logic                   busy_q, busy_d, done_q, done_d;
  logic [COUNT_WIDTH:0]   rem_sh, rem_sub;
  logic [QW:0]            q_round;
  logic                   ge_start;

  assign rem_sh   = {rem_q, 1'b0};
  assign rem_sub  = rem_sh - {1'b0, dvs_q};
  assign ge_start = dividend_i >= divisor_i;

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    qs_d   = qs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvs_d  = divisor_i;
      rem_d  = ge_start ? (dividend_i - divisor_i) : dividend_i;
      qs_d   = {QW'(0), ge_start};
      step_d = StepW'(FRAC_BITS + 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[COUNT_WIDTH-1:0];
        qs_d  = {qs_q[QW-1:0], 1'b1};
      end else begin
        rem_d = rem_sh[COUNT_WIDTH-1:0];
        qs_d  = {qs_q[QW-1:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    qs_q  <= qs_d;
  end

  // Half-up rounding on the extra bit gives ties away from zero on the magnitude.
  assign q_round = qs_q + 1'b1;
  assign quot_o  = q_round[QW:1];
  assign done_o  = done_q;

endmodule

// File: sv/chsh_correlation_witness.sv
// Top level of the CHSH correlation witness: event sequencer, pair statistics and report.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser: kind; tdata: frame fields
// m_axis    out  m_axis_tvalid/tready      tuser: report_valid; tdata: result fields
// apb       in   psel/penable (pready=1)   six configuration registers at 4*index
//
// One input beat is worked on at a time. A start event or the first frame goes from
// the accept straight to the step that loads the result register; a settling frame
// first passes the timer and check steps, and a recorded shot also the report check.
// A shot that closes a report adds four passes of the load, clamp and serial divider
// steps, one per setting pair, and then a saturation step; the divider yields one
// quotient bit a cycle.
// The result register lets the next input beat be taken while a result waits; a
// stalled result holds the core in its last step until the register frees up.
// Reset clears all statistics, the timer and the registers to their defaults.
module chsh_correlation_witness #(
  parameter int unsigned S_FRAC_BITS = 12,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB-style configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [chshcw_pkg::PADDR_W-1:0]    paddr,
  input  logic [chshcw_pkg::PDATA_W-1:0]    pwdata,
  output logic [chshcw_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready,
  // Input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // From bit 0: delta_us[19:0], first_ok, first_bit, second_ok, second_bit
  input  logic [chshcw_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // Bit 0: kind (0 start event, 1 frame update)
  input  logic [0:0]                        s_axis_tuser_i,
  // Result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // From bit 0: rearm, shot_taken, s_estimate[15:0], violation, shots_total[31:0],
  // next_angle_first[15:0], next_angle_second[15:0], five zero bits
  output logic [chshcw_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // Bit 0: report_valid
  output logic [0:0]                        m_axis_tuser_o
);
  import chshcw_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  // The sum of four terms of at most 2^S_FRAC_BITS each, wide enough to compare
  // against the 16-bit saturation limits.
  localparam int unsigned SW = (S_FRAC_BITS + 4 > 17) ? (S_FRAC_BITS + 4) : 17;
  localparam logic signed [SW-1:0] LIM_POS = SW'(2) << S_FRAC_BITS;
  localparam logic signed [SW-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(32767);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(32768);

  cfg_t cfg;

  chshcw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;

  logic                 running_q, running_d;
  logic                 vsent_q, vsent_d;
  logic [1:0]           cur_q, cur_d;
  logic [CW-1:0]        total_q, total_d;
  logic [CW-1:0]        rpt_q, rpt_d;
  logic [31:0]          timer_q, timer_d;
  logic [CW-1:0]        sums_q [4];
  logic [CW-1:0]        sums_d [4];
  logic [CW-1:0]        cnts_q [4];
  logic [CW-1:0]        cnts_d [4];
  frame_t               frm_q, frm_d;
  res_t                 res_q, res_d;
  logic [1:0]           idx_q, idx_d;
  logic                 neg_q, neg_d;
  logic [CW-1:0]        mag_q, mag_d;
  logic signed [SW-1:0] acc_q, acc_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_user_q, out_user_d;

  logic                 in_fire, out_free, settled, do_report, div_start, div_done;
  logic [15:0]          eff_shots;
  logic [CW-1:0]        quad_shots, sum_sel, cnt_sel, step_val;
  logic [32:0]          timer_sum;
  logic [S_FRAC_BITS:0] div_quot;
  logic [15:0]          s_sat, ang_first, ang_second;

  chshcw_serdiv #(
    .COUNT_WIDTH (CW),
    .FRAC_BITS   (S_FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (cnt_sel),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // A zero shot count behaves as one shot per pair.
  assign eff_shots  = (cfg.shots_per_pair == 16'd0) ? 16'd1 : cfg.shots_per_pair;
  assign quad_shots = CW'({eff_shots, 2'b00});

  assign timer_sum = {1'b0, timer_q} + 33'(frm_q.delta_us);
  assign settled   = (timer_q >= cfg.settle_us) && frm_q.first_ok;
  assign step_val  = (frm_q.first_bit ^ frm_q.second_bit) ? {CW{1'b1}} : CW'(1);
  assign do_report = (total_q >= rpt_q) && (cnts_q[0] != '0) && (cnts_q[1] != '0)
                     && (cnts_q[2] != '0) && (cnts_q[3] != '0);

  assign sum_sel = sums_q[idx_q];
  assign cnt_sel = cnts_q[idx_q];

  always_comb begin
    if (acc_q > SAT_MAX) begin
      s_sat = 16'h7fff;
    end else if (acc_q < SAT_MIN) begin
      s_sat = 16'h8000;
    end else begin
      s_sat = acc_q[15:0];
    end
  end

  // Pair 0 = (a,b), 1 = (a,b'), 2 = (a',b), 3 = (a',b').
  assign ang_first  = cur_q[1] ? cfg.angle_a_prime : cfg.angle_a;
  assign ang_second = cur_q[0] ? cfg.angle_b_prime : cfg.angle_b;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!s_axis_tuser_i[0] || !running_q) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_TIMER;
          end
        end
      end
      ST_TIMER:  state_d = ST_CHECK;
      ST_CHECK:  state_d = (settled && frm_q.second_ok) ? ST_RCHK : ST_DONE;
      ST_RCHK:   state_d = do_report ? ST_LOAD : ST_DONE;
      ST_LOAD:   state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT:  state_d = div_done ? ST_ACC : ST_DWAIT;
      ST_ACC:    state_d = (idx_q == PAIR_LAST) ? ST_SAT : ST_LOAD;
      ST_SAT:    state_d = ST_DONE;
      ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    running_d   = running_q;
    vsent_d     = vsent_q;
    cur_d       = cur_q;
    total_d     = total_q;
    rpt_d       = rpt_q;
    timer_d     = timer_q;
    sums_d      = sums_q;
    cnts_d      = cnts_q;
    frm_d       = frm_q;
    res_d       = res_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_valid_d = out_valid_q;
    div_start   = 1'b0;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          frm_d = frame_t'(s_axis_tdata_i);
          res_d = '0;
          if (!s_axis_tuser_i[0]) begin
            // Start event: all statistics go back to zero, registers stay.
            running_d = 1'b0;
            vsent_d   = 1'b0;
            cur_d     = '0;
            total_d   = '0;
            rpt_d     = '0;
            timer_d   = '0;
            for (int i = 0; i < 4; i++) begin
              sums_d[i] = '0;
              cnts_d[i] = '0;
            end
          end else if (!running_q) begin
            // First frame arms the run; its elapsed time is not counted.
            running_d   = 1'b1;
            rpt_d       = quad_shots;
            timer_d     = '0;
            res_d.rearm = 1'b1;
          end
        end
      end
      ST_TIMER: begin
        timer_d = timer_sum[32] ? 32'hffff_ffff : timer_sum[31:0];
      end
      ST_CHECK: begin
        // Without a first-qubit outcome nothing happens and the timer keeps running.
        if (settled) begin
          res_d.rearm = 1'b1;
          timer_d     = '0;
          if (frm_q.second_ok) begin
            for (int i = 0; i < 4; i++) begin
              if (cur_q == 2'(i)) begin
                sums_d[i] = sums_q[i] + step_val;
                cnts_d[i] = cnts_q[i] + CW'(1);
              end
            end
            cur_d            = cur_q + 2'd1;
            total_d          = total_q + CW'(1);
            res_d.shot_taken = 1'b1;
          end
        end
      end
      ST_RCHK: begin
        idx_d = '0;
        acc_d = '0;
      end
      ST_LOAD: begin
        neg_d = sum_sel[CW-1];
        mag_d = sum_sel[CW-1] ? (CW'(0) - sum_sel) : sum_sel;
      end
      ST_CLAMP: begin
        // A sum larger than its count can only follow a counter wrap.
        if (mag_q > cnt_sel) begin
          mag_d = cnt_sel;
        end
      end
      ST_DSTART: div_start = 1'b1;
      ST_DWAIT: ;
      ST_ACC: begin
        if (neg_q ^ (idx_q == PAIR_AB_PRIME)) begin
          acc_d = acc_q - SW'(div_quot);
        end else begin
          acc_d = acc_q + SW'(div_quot);
        end
        idx_d = idx_q + 2'd1;
      end
      ST_SAT: begin
        res_d.report_valid = 1'b1;
        res_d.s_estimate   = s_sat;
        if (!vsent_q && ((acc_q > LIM_POS) || (acc_q < LIM_NEG))) begin
          vsent_d         = 1'b1;
          res_d.violation = 1'b1;
        end
        rpt_d = total_q + quad_shots;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = res_q.report_valid;
          out_data_d  = {5'd0, ang_second, ang_first, 32'(total_q), res_q.violation,
                         res_q.s_estimate, res_q.shot_taken, res_q.rearm};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      vsent_q     <= 1'b0;
      cur_q       <= '0;
      total_q     <= '0;
      rpt_q       <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sums_q[i] <= '0;
        cnts_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      vsent_q     <= vsent_d;
      cur_q       <= cur_d;
      total_q     <= total_d;
      rpt_q       <= rpt_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < 4; i++) begin
        sums_q[i] <= sums_d[i];
        cnts_q[i] <= cnts_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frm_q      <= frm_d;
    res_q      <= res_d;
    idx_q      <= idx_d;
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_user_q;

endmodule

// File: sv/chshcw_checker.sv
// Port-level checker of the correlation witness and its bind to the top level.
`include "chsh_correlation_witness_assert.svh"

module chshcw_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [chshcw_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]                        m_axis_tuser_o
);
  import chshcw_pkg::*;

  logic out_beat;
  assign out_beat = m_axis_tvalid_o;

  // A stalled result beat keeps its payload.
  `CHSHCW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // The core works on one beat at a time, so it is busy right after an accept.
  `CHSHCW_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // Reports close a recorded shot, and every recorded shot asks for a re-arm.
  `CHSHCW_ASSERT_IMPLY(a_report_has_shot, clk_i, rst_ni, out_beat && m_axis_tuser_o[0], m_axis_tdata_o[OUT_SHOT_BIT] && m_axis_tdata_o[OUT_REARM_BIT])

  // A violation is only flagged together with a report.
  `CHSHCW_ASSERT_IMPLY(a_violation_in_report, clk_i, rst_ni, out_beat && m_axis_tdata_o[OUT_VIOL_BIT], m_axis_tuser_o[0])

  // Without a report the estimate field reads as zero.
  `CHSHCW_ASSERT_IMPLY(a_idle_estimate_zero, clk_i, rst_ni, out_beat && !m_axis_tuser_o[0], m_axis_tdata_o[OUT_S_MSB:OUT_S_LSB] == '0)

endmodule

bind chsh_correlation_witness chshcw_checker u_checker (.*);
